// ===== hdl/mu8_pkg.sv =====
// Package for the modified UTF-8 to UTF-16 decoder.
// Holds the sequence phase type, the result record and queue sizing.
// Depends on nothing; every file of the block but mu8_if imports it.
package mu8_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;

  // Result queue between the byte classifier and the output stage.
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // The classifier has three result slots per byte: a broken sequence, a
  // fresh or completed character and an end-of-string flush. No byte fills
  // more than two of them, but the queue keeps room for all three.
  localparam int MAX_PUSH = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TWO_LEAD,
    PH_THREE_LEAD,
    PH_THREE_MID
  } mu8_phase_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  bytes_used;
    logic        invalid_seq;
    logic        last_char;
  } mu8_unit_t;

  typedef struct packed {
    logic [1:0]                 n;
    mu8_unit_t [MAX_PUSH-1:0]   unit;
  } mu8_push_t;

endpackage

// ===== hdl/mu8_if.sv =====
// Valid/ready channel interfaces of the decoder: byte input and result output.
// Depends on nothing.
interface mu8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, data_byte, end_of_string, input ready);
  modport sink   (input valid, data_byte, end_of_string, output ready);
endinterface

interface mu8_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  bytes_used;
  logic        invalid_seq;
  logic [15:0] char_count;
  logic        last_char;

  modport source (output valid, code_unit, bytes_used, invalid_seq, char_count, last_char,
                  input ready);
  modport sink   (input valid, code_unit, bytes_used, invalid_seq, char_count, last_char,
                  output ready);
endinterface

// ===== hdl/mu8_front.sv =====
// Byte classifier: tracks the sequence phase and turns each byte into up to
// two results for the queue. Depends on mu8_pkg and mu8_if.
module mu8_front (
  input  logic              clk,
  input  logic              rst_n,
  mu8_in_if.sink            in_ch,
  input  logic              room,
  output mu8_pkg::mu8_push_t push
);
  import mu8_pkg::*;

  mu8_phase_t phase_r, phase_nxt, phase_mid;
  logic [9:0] pv_r, pv_nxt, pv_mid;

  logic [7:0] c;
  logic       eos, accept, cont, lead2, lead3;

  assign c      = in_ch.data_byte;
  assign eos    = in_ch.end_of_string;
  assign accept = in_ch.valid && room;
  assign cont   = (c[7:6] == 2'b10);
  assign lead2  = (c[7:5] == 3'b110);
  assign lead3  = (c[7:4] == 4'b1110);
  assign in_ch.ready = room;

  // Phase after the byte, before any end-of-string flush.
  always_comb begin
    logic fresh;
    fresh     = 1'b0;
    phase_mid = PH_IDLE;
    pv_mid    = pv_r;
    case (phase_r)
      PH_IDLE: fresh = 1'b1;
      PH_TWO_LEAD: fresh = !cont;
      PH_THREE_LEAD: begin
        if (cont) begin
          phase_mid = PH_THREE_MID;
          pv_mid    = {pv_r[3:0], c[5:0]};
        end else begin
          fresh = 1'b1;
        end
      end
      PH_THREE_MID: fresh = !cont;
      default: fresh = 1'b1;
    endcase
    if (fresh) begin
      if (lead2) begin
        phase_mid = PH_TWO_LEAD;
        pv_mid    = {5'd0, c[4:0]};
      end else if (lead3) begin
        phase_mid = PH_THREE_LEAD;
        pv_mid    = {6'd0, c[3:0]};
      end
    end
  end

  // Next state: a finished string returns everything to rest.
  always_comb begin
    phase_nxt = phase_r;
    pv_nxt    = pv_r;
    if (accept) begin
      if (eos) begin
        phase_nxt = PH_IDLE;
        pv_nxt    = '0;
      end else begin
        phase_nxt = phase_mid;
        pv_nxt    = pv_mid;
      end
    end
  end

  // Outputs: slot 0 is a broken sequence, slot 1 a completed or plain
  // character, slot 2 the flush of a sequence cut off by the string's end.
  always_comb begin
    mu8_unit_t        slot [MAX_PUSH];
    logic [MAX_PUSH-1:0] sv;
    logic [1:0]       n;
    logic             fresh;

    for (int k = 0; k < MAX_PUSH; k++) slot[k] = '0;
    sv    = '0;
    fresh = 1'b0;

    case (phase_r)
      PH_IDLE: fresh = 1'b1;
      PH_TWO_LEAD: begin
        if (cont) begin
          sv[1]   = 1'b1;
          slot[1] = '{code_unit: {5'd0, pv_r[4:0], c[5:0]}, bytes_used: 2'd2,
                      invalid_seq: 1'b0, last_char: 1'b0};
        end else begin
          sv[0]   = 1'b1;
          slot[0] = '{code_unit: 16'd0, bytes_used: 2'd1, invalid_seq: 1'b1,
                      last_char: 1'b0};
          fresh   = 1'b1;
        end
      end
      PH_THREE_LEAD: begin
        if (!cont) begin
          sv[0]   = 1'b1;
          slot[0] = '{code_unit: 16'd0, bytes_used: 2'd1, invalid_seq: 1'b1,
                      last_char: 1'b0};
          fresh   = 1'b1;
        end
      end
      PH_THREE_MID: begin
        if (cont) begin
          sv[1]   = 1'b1;
          slot[1] = '{code_unit: {pv_r, c[5:0]}, bytes_used: 2'd3,
                      invalid_seq: 1'b0, last_char: 1'b0};
        end else begin
          sv[0]   = 1'b1;
          slot[0] = '{code_unit: 16'd0, bytes_used: 2'd2, invalid_seq: 1'b1,
                      last_char: 1'b0};
          fresh   = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase

    // A fresh byte that is not a lead byte stands for itself.
    if (fresh && !lead2 && !lead3) begin
      sv[1]   = 1'b1;
      slot[1] = '{code_unit: {8'd0, c}, bytes_used: 2'd1, invalid_seq: 1'b0,
                  last_char: 1'b0};
    end

    if (eos && (phase_mid != PH_IDLE)) begin
      sv[2]   = 1'b1;
      slot[2] = '{code_unit: 16'd0,
                  bytes_used: (phase_mid == PH_THREE_MID) ? 2'd2 : 2'd1,
                  invalid_seq: 1'b1, last_char: 1'b0};
    end

    // The final result of a string carries the last-character mark.
    slot[2].last_char = eos;
    slot[1].last_char = eos && !sv[2];
    slot[0].last_char = eos && !sv[2] && !sv[1];

    push.unit = '0;
    n = 2'd0;
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (sv[k]) begin
        push.unit[n] = slot[k];
        n = n + 2'd1;
      end
    end
    push.n = accept ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pv_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      pv_r    <= pv_nxt;
    end
  end

endmodule

// ===== hdl/mu8_queue.sv =====
// Result queue: takes up to three results a cycle while it has room, gives one a cycle while the output stage is ready.
// Depends on mu8_pkg.
module mu8_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  mu8_pkg::mu8_push_t  push,
  output logic                room,
  output logic                q_valid,
  input  logic                q_ready,
  output mu8_pkg::mu8_unit_t  q_unit
);
  import mu8_pkg::*;

  mu8_unit_t     mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            pop;

  assign q_valid = (count_r != '0);
  assign pop     = q_valid && q_ready;
  assign q_unit  = mem[rd_ptr_r];
  // Room for a worst-case byte is kept before a byte is taken.
  assign room    = (count_r <= (Q_AW+1)'(Q_DEPTH - MAX_PUSH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    count_nxt  = count_r + (Q_AW+1)'(push.n) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (2'(k) < push.n) mem[wr_ptr_r + Q_AW'(k)] <= push.unit[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/mu8_back.sv =====
// Output stage: numbers each character and holds it in the output register.
// Depends on mu8_pkg and mu8_if.
module mu8_back #(
  parameter int COUNT_WIDTH = mu8_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  mu8_pkg::mu8_unit_t q_unit,
  mu8_out_if.source          out_ch
);
  import mu8_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_inc;
  logic [31:0]            count_ext;
  logic                   valid_r, valid_nxt, take;
  mu8_unit_t              unit_r;
  logic [15:0]            shown_r, shown_nxt;

  assign q_ready   = !valid_r || out_ch.ready;
  assign take      = q_valid && q_ready;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign count_ext = 32'(count_inc);

  always_comb begin
    valid_nxt = take ? 1'b1 : (valid_r && !out_ch.ready);
    count_nxt = count_r;
    shown_nxt = shown_r;
    if (take) begin
      // The count restarts once the string's final character is out.
      count_nxt = q_unit.last_char ? '0 : count_inc;
      shown_nxt = (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take) unit_r <= q_unit;
    shown_r <= shown_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.code_unit   = unit_r.code_unit;
  assign out_ch.bytes_used  = unit_r.bytes_used;
  assign out_ch.invalid_seq = unit_r.invalid_seq;
  assign out_ch.char_count  = shown_r;
  assign out_ch.last_char   = unit_r.last_char;

endmodule

// ===== hdl/modified_utf8_to_utf16_decoder.sv =====
// Top level of the modified UTF-8 to UTF-16 decoder.
// Depends on mu8_pkg, mu8_if, mu8_front, mu8_queue and mu8_back.
//
// The decoder takes one byte per request on in_ch and delivers 16-bit code
// units on out_ch. It accepts a byte in every cycle while its eight-entry
// result queue has room for three more results, and delivers one result per
// cycle from a registered output while out_ch.ready is high, so a stream that
// yields at most one character per byte runs at one byte per clock. A byte that
// breaks a sequence can yield two results, the broken sequence and the byte's
// own character or flush; the single-result output port then sets the rate, and
// in_ch.ready drops once the queue backs up. Two- and three-byte sequences
// are gathered in the classifier's phase register; broken sequences come out
// as code unit 0 with invalid_seq set. The character count is kept in the
// output stage, saturates at 2^COUNT_WIDTH-1 (shown at most as 65535) and
// restarts after the result marked last_char. A result waits in the output
// register for out_ch.ready while new bytes keep entering the queue. Reset
// is synchronous and active low; nothing needs clearing beyond the control
// registers.
module modified_utf8_to_utf16_decoder #(
  parameter int COUNT_WIDTH = mu8_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  mu8_in_if.sink     in_ch,
  mu8_out_if.source  out_ch
);
  import mu8_pkg::*;

  mu8_push_t push;
  mu8_unit_t q_unit;
  logic      room, q_valid, q_ready;

  // Front: classify each byte and gather multi-byte sequences.
  mu8_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  // Queue: lets the byte side and the result side stall independently.
  mu8_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_unit  (q_unit)
  );

  // Back: number the characters and drive the output register.
  mu8_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_unit  (q_unit),
    .out_ch  (out_ch)
  );

endmodule

// ===== sim/modified_utf8_to_utf16_decoder_tb.sv =====
// Self-checking testbench for the modified UTF-8 to UTF-16 decoder.
// Depends on mu8_pkg, the mu8_in_if/mu8_out_if interfaces and the decoder top level.
// Directed strings and random strings, checked per result.
module modified_utf8_to_utf16_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mu8_pkg::*;

  // Run shape.
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_BYTES  = 620;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int REPORT_CAP    = 40;
  localparam int PRESSURE_AT   = 120;
  localparam int PRESSURE_LEN  = 400;

  // Byte classes that the decoder distinguishes by the top bits.
  localparam logic [3:0]  LEAD2_LO     = 4'hC;
  localparam logic [3:0]  LEAD2_HI     = 4'hD;
  localparam logic [3:0]  LEAD3        = 4'hE;
  localparam logic [1:0]  CONT_TAG     = 2'b10;
  localparam logic [15:0] COUNT_CEIL   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } byte_req_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  bytes_used;
    logic        invalid_seq;
    logic [15:0] char_count;
    logic        last_char;
  } char_unit_t;

  logic clk;
  logic rst_n;

  mu8_in_if  in_ch ();
  mu8_out_if out_ch ();

  modified_utf8_to_utf16_decoder #(
    .COUNT_WIDTH (16)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes waiting to be offered, and the characters the decoder owes us.
  byte_req_t  byte_fifo[$];
  char_unit_t decoded_units[$];

  int bytes_queued  = 0;
  int bytes_taken   = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // Idle pacing state of both sides.
  int  send_gap      = 0;
  int  send_calm     = 0;
  int  recv_gap      = 0;
  int  recv_calm     = 0;
  int  hold_left     = 0;
  bit  pressure_done = 1'b0;

  // Shadow of the decoder state: sequence phase, gathered payload bits and
  // the running character count of the current string.
  mu8_phase_t  seq_state       = PH_IDLE;
  logic [9:0]  gathered_bits   = '0;
  logic [15:0] chars_in_string = '0;

  // Delay before the next request or the next ready cycle. Mostly none or a
  // few cycles, now and then a long one, and occasionally a calm stretch
  // with no idling at all.
  function automatic int pick_delay(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eos);
    byte_req_t req;
    req.data_byte     = b;
    req.end_of_string = eos;
    byte_fifo.push_back(req);
  endtask

  // One emitted character: bump the saturating count and queue the result.
  task automatic push_unit(input logic [15:0] unit, input logic [1:0] used, input logic bad);
    char_unit_t u;
    if (chars_in_string != COUNT_CEIL) chars_in_string++;
    u.code_unit   = unit;
    u.bytes_used  = used;
    u.invalid_seq = bad;
    u.char_count  = chars_in_string;
    u.last_char   = 1'b0;
    decoded_units.push_back(u);
  endtask

  // A byte seen with no sequence pending: either a lead byte that opens a
  // sequence, or a character of its own.
  task automatic start_char(input logic [7:0] b);
    case (b[7:4])
      LEAD2_LO, LEAD2_HI: begin
        seq_state     = PH_TWO_LEAD;
        gathered_bits = {5'd0, b[4:0]};
      end
      LEAD3: begin
        seq_state     = PH_THREE_LEAD;
        gathered_bits = {6'd0, b[3:0]};
      end
      default: begin
        push_unit({8'd0, b}, 2'd1, 1'b0);
      end
    endcase
  endtask

  // Work out every character that one accepted byte releases. A broken
  // sequence yields a zero unit first, and the byte is then decoded afresh.
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic cont;
    int   units_prior;
    cont        = (b[7:6] == CONT_TAG);
    units_prior = decoded_units.size();
    case (seq_state)
      PH_TWO_LEAD: begin
        seq_state = PH_IDLE;
        if (cont) begin
          push_unit({5'd0, gathered_bits[4:0], b[5:0]}, 2'd2, 1'b0);
        end else begin
          push_unit(16'd0, 2'd1, 1'b1);
          start_char(b);
        end
      end
      PH_THREE_LEAD: begin
        if (cont) begin
          seq_state     = PH_THREE_MID;
          gathered_bits = {gathered_bits[3:0], b[5:0]};
        end else begin
          seq_state = PH_IDLE;
          push_unit(16'd0, 2'd1, 1'b1);
          start_char(b);
        end
      end
      PH_THREE_MID: begin
        seq_state = PH_IDLE;
        if (cont) begin
          push_unit({gathered_bits, b[5:0]}, 2'd3, 1'b0);
        end else begin
          push_unit(16'd0, 2'd2, 1'b1);
          start_char(b);
        end
      end
      default: begin
        start_char(b);
      end
    endcase
    // At the end of a string a pending sequence is flushed as broken, the
    // final character is marked, and the shadow state starts over.
    if (eos) begin
      if (seq_state == PH_TWO_LEAD || seq_state == PH_THREE_LEAD) begin
        push_unit(16'd0, 2'd1, 1'b1);
      end else if (seq_state == PH_THREE_MID) begin
        push_unit(16'd0, 2'd2, 1'b1);
      end
      if (decoded_units.size() > units_prior) begin
        decoded_units[decoded_units.size()-1].last_char = 1'b1;
      end
      seq_state       = PH_IDLE;
      gathered_bits   = '0;
      chars_in_string = '0;
    end
  endtask

  // Clock, and known values on every input from time zero.
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Byte driver. A request is predicted at the edge where it is taken; the
  // next one is presented only once the current one has gone, so valid is
  // assigned once per edge and never dropped under a waiting request.
  always @(posedge clk) begin : drive_bytes
    byte_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.data_byte, in_ch.end_of_string);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (byte_fifo.size() > 0) begin
          nxt = byte_fifo.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.data_byte     <= nxt.data_byte;
          in_ch.end_of_string <= nxt.end_of_string;
          send_gap = pick_delay(send_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver pacing. Once, early on, the receiver holds
  // ready low for a long stretch while bytes keep arriving, so the result
  // queue fills and the decoder has to stall its input.
  always @(posedge clk) begin : check_units
    char_unit_t want;
    char_unit_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.code_unit   = out_ch.code_unit;
        got.bytes_used  = out_ch.bytes_used;
        got.invalid_seq = out_ch.invalid_seq;
        got.char_count  = out_ch.char_count;
        got.last_char   = out_ch.last_char;
        if (decoded_units.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP) begin
            $display("%0t: unexpected unit=%h used=%0d bad=%b count=%0d last=%b",
                     $time, got.code_unit, got.bytes_used, got.invalid_seq,
                     got.char_count, got.last_char);
          end
        end else begin
          want = decoded_units.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
              $display("%0t: mismatch expected unit=%h used=%0d bad=%b count=%0d last=%b",
                       $time, want.code_unit, want.bytes_used, want.invalid_seq,
                       want.char_count, want.last_char);
              $display("%0t:          actual   unit=%h used=%0d bad=%b count=%0d last=%b",
                       $time, got.code_unit, got.bytes_used, got.invalid_seq,
                       got.char_count, got.last_char);
            end
          end
        end
      end
      if (!pressure_done && bytes_taken >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_delay(recv_calm);
      end
    end
  end

  // Cycles in which neither channel moved a request.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL modified_utf8_to_utf16_decoder");
    $finish;
  end

  // Stimulus. The whole byte stream is built before reset is released.
  initial begin : stimulus
    int random_end;
    int n_chars;
    int kind;

    // Single-byte characters at the edges of the pass-through ranges,
    // including a lone continuation byte outside any sequence.
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'hFF, 1'b0);
    // Overlong two-byte NUL, then the largest two-byte value.
    add_byte(8'hC0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hDF, 1'b0);
    add_byte(8'hBF, 1'b0);
    // Overlong three-byte zero, then the largest three-byte value.
    add_byte(8'hE0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    // Two-byte lead broken by a plain character: two results from one byte.
    add_byte(8'hC3, 1'b0);
    add_byte(8'h41, 1'b0);
    // Three-byte lead broken straight away.
    add_byte(8'hE2, 1'b0);
    add_byte(8'h41, 1'b0);
    // Three-byte sequence broken after one continuation by a new lead,
    // which then completes normally.
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'h41, 1'b1);
    // String ending inside a three-byte sequence after one continuation.
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b1);
    // Final byte breaks a sequence and opens another, which is flushed.
    add_byte(8'hC2, 1'b0);
    add_byte(8'hC3, 1'b1);

    // Random strings: mostly well-formed characters with the odd truncated
    // sequence, the rest raw noise with random end markers.
    random_end = byte_fifo.size() + RANDOM_BYTES;
    while (byte_fifo.size() < random_end) begin
      n_chars = $urandom_range(1, 10);
      if ($urandom_range(0, 4) == 0) begin
        repeat (n_chars) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        repeat (n_chars) begin
          kind = $urandom_range(0, 9);
          case (kind)
            0, 1, 2: add_byte(8'($urandom_range(8'h00, 8'h7F)), 1'b0);
            3: begin
              if ($urandom_range(0, 1) == 0) begin
                add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
              end else begin
                add_byte(8'($urandom_range(8'hF0, 8'hFF)), 1'b0);
              end
            end
            4, 5: begin
              add_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
              add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
            6, 7: begin
              add_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
              add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
              add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
            8: begin
              add_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
            end
            default: begin
              add_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
              if ($urandom_range(0, 1) == 0) begin
                add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
              end
            end
          endcase
        end
      end
      byte_fifo[byte_fifo.size()-1].end_of_string = 1'b1;
    end

    // A short closing string shows the count restarting.
    add_byte(8'h5A, 1'b0);
    add_byte(8'h5A, 1'b1);

    bytes_queued = byte_fifo.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    wait (bytes_taken == bytes_queued);
    wait (decoded_units.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS modified_utf8_to_utf16_decoder");
    end else begin
      $display("FAIL modified_utf8_to_utf16_decoder");
    end
    $finish;
  end

endmodule
